[design/snm_pkg.sv]
package snm_pkg;

    localparam int MaxInputs  = 1024;
    localparam int ValueWidth = 16;
    localparam int AddrWidth  = $clog2(MaxInputs);
    localparam int CntWidth   = 11;
    localparam int AccWidth   = 48;
    localparam int QueueDepth = 2;

    localparam logic [1:0] REQ_FWD   = 2'd0;
    localparam logic [1:0] REQ_UPD   = 2'd1;
    localparam logic [1:0] REQ_LOADW = 2'd2;
    localparam logic [1:0] REQ_LOADB = 2'd3;

    localparam logic [0:0] REG_LR = 1'b0;
    localparam logic [0:0] REG_N  = 1'b1;

    localparam logic [CntWidth-1:0] CntMax = '1;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EXEC,
        BK_FIN,
        BK_ACT,
        BK_OUT
    } bk_state_t;

    // Classified word handed from the front part to the back part.
    typedef struct packed {
        logic [1:0]                  kind;
        logic signed [ValueWidth-1:0] val;
        logic signed [15:0]          dlt;
        logic                        last;
        logic [AddrWidth-1:0]        idx;
        logic                        usable;
        logic                        err;
    } snm_op_t;

    function automatic logic signed [ValueWidth-1:0] sat_value(input logic signed [63:0] v);
        logic signed [63:0] hi;
        hi = (64'sd1 <<< (ValueWidth - 1)) - 64'sd1;
        if (v > hi)
            sat_value = hi[ValueWidth-1:0];
        else if (v < -hi - 64'sd1)
            sat_value = ~hi[ValueWidth-1:0];
        else
            sat_value = v[ValueWidth-1:0];
    endfunction

    // Half-up rounding: add half then arithmetic shift.
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input int n);
        round_shift = (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic logic [15:0] sigmoid_q16(input logic signed [31:0] x);
        logic [32:0] a;
        logic [33:0] y;
        a = x[31] ? 33'(-$signed({x[31], x})) : {1'b0, x};
        if (a < 33'd4096)
            y = 34'd32768 + {a[31:0], 2'b00};
        else if (a < 33'd9728)
            y = 34'd40960 + {a[32:0], 1'b0};
        else if (a < 33'd20480)
            y = 34'd55296 + {2'b00, a[32:1]};
        else
            y = 34'd65536;
        if (x[31])
            y = 34'd65536 - y;
        if (y > 34'd65535)
            sigmoid_q16 = 16'hFFFF;
        else
            sigmoid_q16 = y[15:0];
    endfunction

endpackage

[design/snm_ram.sv]
module snm_ram #(
    parameter int Width = 16,
    parameter int Depth = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

[design/snm_front.sv]
module snm_front import snm_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_take,
    input  logic [1:0]            req_type,
    input  logic [ValueWidth-1:0] value_in,
    input  logic [15:0]           delta,
    input  logic                  last,
    input  logic [CntWidth-1:0]   n_inputs,
    output snm_op_t               op
);

    // Element counter lives here; each word is tagged with its index.
    logic [CntWidth-1:0] count_reg, count_next, count_inc;
    logic                is_elem;

    assign count_inc = (count_reg < CntMax) ? count_reg + 1'b1 : count_reg;
    assign is_elem   = (req_type == REQ_FWD) || (req_type == REQ_UPD);

    always_comb
    begin
        op.kind   = req_type;
        op.val    = $signed(value_in);
        op.dlt    = $signed(delta);
        op.last   = last;
        op.idx    = count_reg[AddrWidth-1:0];
        op.usable = (count_reg < CntWidth'(MaxInputs)) && (count_reg < n_inputs);
        if (req_type == REQ_LOADW)
            op.usable = count_reg < CntWidth'(MaxInputs);
        op.err    = (count_inc != n_inputs) || (n_inputs > CntWidth'(MaxInputs));
    end

    always_comb
    begin
        count_next = count_reg;
        if (in_take)
        begin
            case (req_type)
                REQ_LOADB: count_next = '0;
                REQ_LOADW: count_next = count_inc;
                default:   count_next = (is_elem && last) ? '0 : count_inc;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

[design/snm_queue.sv]
module snm_queue import snm_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  snm_op_t push_op,
    input  logic    pop,
    output snm_op_t head_op,
    output logic    not_empty,
    output logic    full
);

    localparam int PtrWidth = $clog2(QueueDepth);

    snm_op_t               slot_reg [QueueDepth];
    logic [PtrWidth-1:0]   wp_reg, rp_reg;
    logic [PtrWidth:0]     fill_reg;

    assign head_op   = slot_reg[rp_reg];
    assign not_empty = fill_reg != '0;
    assign full      = fill_reg == (PtrWidth+1)'(QueueDepth);

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            fill_reg <= fill_reg + (PtrWidth+1)'(push) - (PtrWidth+1)'(pop);
        end
    end

endmodule

[design/snm_back.sv]
module snm_back import snm_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  snm_op_t             head_op,
    input  logic                not_empty,
    output logic                pop,
    input  logic [15:0]         learning_rate,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  raw_sum,
    output logic [15:0]         activation,
    output logic                length_error,
    output logic                pass_kind
);

    bk_state_t state_reg, state_next;
    snm_op_t   op_reg;
    logic signed [32:0]           ld_reg;     // learning_rate * delta
    logic signed [AccWidth-1:0]   acc_reg;
    logic signed [ValueWidth-1:0] bias_reg;
    logic signed [31:0]           raw_reg;
    logic [15:0]                  act_reg;
    logic                         err_reg, kind_reg;

    logic                         ram_we;
    logic [ValueWidth-1:0]        ram_wdata, ram_rdata;
    logic signed [ValueWidth-1:0] w;
    logic signed [32:0]           ld_next;
    logic signed [31:0]           prod;
    logic signed [48:0]           upd_prod;
    logic signed [63:0]           acc_sum, step, bstep, total;
    logic signed [63:0]           rnd;
    logic signed [AccWidth-1:0]   acc_new;
    logic signed [31:0]           raw;
    logic                         take, emit;

    snm_ram #(.Width(ValueWidth), .Depth(MaxInputs)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (op_reg.idx),
        .wdata (ram_wdata),
        .raddr (head_op.idx),
        .rdata (ram_rdata)
    );

    assign w    = $signed(ram_rdata);
    assign take = not_empty && (state_reg == BK_IDLE);
    assign pop  = take;
    assign emit = (state_reg == BK_EXEC) && op_reg.last
                  && (op_reg.kind == REQ_FWD || op_reg.kind == REQ_UPD);

    // First multiply of the update step runs while the weight is read.
    assign ld_next = $signed({1'b0, learning_rate}) * $signed(head_op.dlt);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (take) state_next = BK_EXEC;
            BK_EXEC: state_next = emit ? BK_FIN : BK_IDLE;
            BK_FIN:  state_next = BK_ACT;
            BK_ACT:  state_next = BK_OUT;
            BK_OUT:  if (!out_stall) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid    = state_reg == BK_OUT;
        raw_sum      = raw_reg;
        activation   = act_reg;
        length_error = err_reg;
        pass_kind    = kind_reg;
    end

    // Datapath for the word in BK_EXEC (weight already read).
    always_comb
    begin
        prod     = w * $signed(op_reg.val);
        acc_sum  = 64'(acc_reg) + 64'(prod);
        if (acc_sum > 64'sh7FFFFFFFFFFF)
            acc_new = 48'sh7FFFFFFFFFFF;
        else if (acc_sum < -64'sh800000000000)
            acc_new = 48'sh800000000000;
        else
            acc_new = acc_sum[AccWidth-1:0];
        upd_prod = ld_reg * $signed(op_reg.val);
        step     = round_shift(64'(upd_prod), 28);
        bstep    = round_shift(64'(ld_reg), 16);
        ram_we    = 1'b0;
        ram_wdata = '0;
        if (state_reg == BK_EXEC)
        begin
            if (op_reg.kind == REQ_LOADW && op_reg.usable)
            begin
                ram_we    = 1'b1;
                ram_wdata = sat_value(64'(op_reg.val));
            end
            else if (op_reg.kind == REQ_UPD && op_reg.usable)
            begin
                ram_we    = 1'b1;
                ram_wdata = sat_value(64'(w) - step);
            end
        end
    end

    // Final sum for BK_FIN: bias in, round to Q12, saturate to 32 bits.
    always_comb
    begin
        total = 64'(acc_reg) + (64'(bias_reg) <<< 12);
        if (total > 64'sh7FFFFFFFFFFF)
            total = 64'sh7FFFFFFFFFFF;
        else if (total < -64'sh800000000000)
            total = -64'sh800000000000;
        rnd = round_shift(total, 12);
        if (rnd > 64'sh7FFFFFFF)
            raw = 32'sh7FFFFFFF;
        else if (rnd < -64'sh80000000)
            raw = 32'sh80000000;
        else
            raw = rnd[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg <= head_op;
            ld_reg <= ld_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            acc_reg   <= '0;
            bias_reg  <= '0;
            raw_reg   <= '0;
            act_reg   <= '0;
            err_reg   <= 1'b0;
            kind_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                BK_EXEC:
                begin
                    case (op_reg.kind)
                        REQ_LOADB:
                        begin
                            bias_reg <= sat_value(64'(op_reg.val));
                            acc_reg  <= '0;
                        end
                        REQ_FWD:
                        begin
                            if (op_reg.usable)
                                acc_reg <= acc_new;
                        end
                        REQ_UPD:
                        begin
                            if (op_reg.last)
                                bias_reg <= sat_value(64'(bias_reg) - bstep);
                        end
                        default: ;
                    endcase
                    if (emit)
                    begin
                        err_reg  <= op_reg.err;
                        kind_reg <= op_reg.kind == REQ_UPD;
                    end
                end
                BK_FIN:
                begin
                    raw_reg <= kind_reg ? '0 : raw;
                    acc_reg <= '0;
                end
                BK_ACT:
                    act_reg <= kind_reg ? '0 : sigmoid_q16(raw_reg);
                default: ;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_OUT && out_stall) |=> state_reg == BK_OUT)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == BK_IDLE)
        else $error("pop outside idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(raw_sum) && $stable(activation)
                                     && $stable(length_error) && $stable(pass_kind))
        else $error("result changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pass_kind) |-> raw_sum == 32'sd0 && activation == 16'd0)
        else $error("update result not zero");

endmodule

[design/sigmoid_neuron_mac_with_update.sv]
// One sigmoid neuron with an in-place gradient update. Words carry a
// req_type: forward element, update element, weight load or bias load.
// The front part counts elements and tags each word with its weight index;
// a two-entry queue feeds the back part, which reads the weight from a
// 1024x16 RAM (read in BK_IDLE), then computes and writes back in BK_EXEC.
// The back part takes no new word until it is back in BK_IDLE; the queue
// stalls the input once it holds two words. A word that ends a pass then
// goes through BK_FIN (final sum) and BK_ACT (sigmoid), and waits in the
// output register until taken. A result appears only on a forward or
// update word with last set.
module sigmoid_neuron_mac_with_update import snm_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          req_type,
    input  logic signed [15:0]  value_in,
    input  logic signed [15:0]  delta,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  raw_sum,
    output logic [15:0]         activation,
    output logic                length_error,
    output logic                pass_kind
);

    logic [15:0]         lr_reg;
    logic [CntWidth-1:0] n_reg;
    snm_op_t             push_op, head_op;
    logic                in_take, pop, not_empty, full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg <= 16'd6554;
            n_reg  <= CntWidth'(784);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LR:  lr_reg <= cfg_data;
                REG_N:   n_reg  <= cfg_data[CntWidth-1:0];
                default: ;
            endcase
        end
    end

    assign in_stall = full;
    assign in_take  = in_valid && !full;

    snm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_take  (in_take),
        .req_type (req_type),
        .value_in (value_in),
        .delta    (delta),
        .last     (last),
        .n_inputs (n_reg),
        .op       (push_op)
    );

    snm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_take),
        .push_op   (push_op),
        .pop       (pop),
        .head_op   (head_op),
        .not_empty (not_empty),
        .full      (full)
    );

    snm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_op       (head_op),
        .not_empty     (not_empty),
        .pop           (pop),
        .learning_rate (lr_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .raw_sum       (raw_sum),
        .activation    (activation),
        .length_error  (length_error),
        .pass_kind     (pass_kind)
    );

endmodule
